@@ src/bsca_pkg.sv @@
package bsca_pkg;

	// adapter_mode codes
	localparam logic [1:0] MODE_PARALLEL = 2'd0;
	localparam logic [1:0] MODE_SERIAL   = 2'd1;
	localparam logic [1:0] MODE_CLOCKED  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_MODE     = 2'd0;
	localparam logic [1:0] REG_ATTACHED = 2'd1;

	// bus access kind and port
	localparam logic OP_READ   = 1'b0;
	localparam logic OP_WRITE  = 1'b1;
	localparam logic PORT_DATA = 1'b0;
	localparam logic PORT_CFG  = 1'b1;

	localparam logic [7:0] BYTE_ONES    = 8'hFF;
	localparam logic [7:0] BYTE_ZERO    = 8'h00;
	localparam logic [7:0] READ_BIT_SET = 8'h80;
	localparam logic [2:0] LAST_BIT     = 3'd7;

	typedef struct packed {
		logic       op;
		logic       port_select;
		logic [7:0] write_data;
		logic [7:0] card_reply;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       exchange_valid;
		logic [7:0] exchange_byte;
		logic       select_update;
		logic       select_level;
	} result_t;

	typedef struct packed {
		logic [7:0] reply_latch;
		logic [7:0] shift_byte;
		logic [2:0] bit_count;
		logic       last_clock_level;
	} adapt_state_t;

	typedef struct packed {
		logic [1:0] adapter_mode;
		logic       card_attached;
	} cfg_t;

endpackage

@@ src/bsca_engine.sv @@
// Per-access decode: result word and next adapter state.
module bsca_engine import bsca_pkg::*; (
	input  item_t        item,
	input  cfg_t         cfg,
	input  adapt_state_t st,
	output result_t      res,
	output adapt_state_t st_next
);

	logic       shift_en;
	logic       shift_bit;
	logic [7:0] shifted;
	logic [2:0] cnt_inc;
	logic [2:0] sel_idx;
	logic       clk_bit;

	assign shifted = {st.shift_byte[6:0], shift_bit};
	assign cnt_inc = st.bit_count + 3'd1;
	assign sel_idx = LAST_BIT - st.bit_count;
	assign clk_bit = item.write_data[1];

	always_comb begin
		res       = '0;
		st_next   = st;
		shift_en  = 1'b0;
		shift_bit = 1'b0;

		if (item.op == OP_READ) begin
			if (!cfg.card_attached) begin
				res.read_data = BYTE_ONES;
			end else if (item.port_select == PORT_DATA) begin
				if (cfg.adapter_mode == MODE_CLOCKED)
					res.read_data = st.reply_latch[sel_idx] ? READ_BIT_SET : BYTE_ZERO;
				else
					res.read_data = st.reply_latch;
			end else begin
				res.read_data = (cfg.adapter_mode == MODE_PARALLEL) ? BYTE_ZERO : BYTE_ONES;
			end
		end else if (cfg.card_attached) begin
			if (item.port_select == PORT_CFG) begin
				if (cfg.adapter_mode == MODE_PARALLEL) begin
					res.select_update = 1'b1;
					res.select_level  = item.write_data[0];
				end
			end else begin
				unique case (cfg.adapter_mode)
					MODE_PARALLEL: begin
						res.exchange_valid = 1'b1;
						res.exchange_byte  = item.write_data;
					end
					MODE_SERIAL: begin
						shift_en  = 1'b1;
						shift_bit = item.write_data[7];
					end
					MODE_CLOCKED: begin
						res.select_update        = 1'b1;
						res.select_level         = item.write_data[2];
						shift_en                 = !st.last_clock_level && clk_bit;
						shift_bit                = item.write_data[0];
						st_next.last_clock_level = clk_bit;
					end
					default: ;
				endcase
			end

			if (shift_en) begin
				st_next.shift_byte = shifted;
				st_next.bit_count  = cnt_inc;
				if (st.bit_count == LAST_BIT) begin
					res.exchange_valid = 1'b1;
					res.exchange_byte  = shifted;
				end
			end

			if (res.exchange_valid)
				st_next.reply_latch = item.card_reply;
		end
	end

endmodule

@@ src/bus_to_spi_card_adapter_unit.sv @@
// Bus-to-SPI card adapter. Each input word is one host bus access (read or
// write, data or configuration port) and gives exactly one result word:
// read data, an optional byte sent to the card, and an optional chip select
// update. Modes: 0 sends whole bytes, 1 shifts in write_data[7] per write,
// 2 shifts in write_data[0] on a rising edge of write_data[1] and drives
// chip select from write_data[2]. card_reply is latched whenever a byte
// completes and is read back on the data port. Throughput is one access per
// cycle while out_ready is high. The input register is loaded on accept,
// and the result register through the single decode stage once it is free
// or being drained; the stage also owns the shift register, bit counter
// and reply latch. Configuration is to be written through cfg_valid/
// cfg_index/cfg_data only while idle, which the block does not enforce;
// cfg_ready is always high and indexes other than 0 and 1 are ignored.
module bus_to_spi_card_adapter_unit import bsca_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,

	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,

	input  logic       in_valid,
	output logic       in_ready,
	input  logic       op,
	input  logic       port_select,
	input  logic [7:0] write_data,
	input  logic [7:0] card_reply,

	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_data,
	output logic       exchange_valid,
	output logic [7:0] exchange_byte,
	output logic       select_update,
	output logic       select_level
);

	cfg_t         cfg_q;
	adapt_state_t st_q;
	adapt_state_t st_next;
	item_t        item_s1;
	logic         valid_s1;
	result_t      res;
	result_t      res_s2;
	logic         valid_s2;
	logic         advance;

	// config registers: always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == REG_MODE)
				cfg_q.adapter_mode <= cfg_data[1:0];
			else if (cfg_index == REG_ATTACHED)
				cfg_q.card_attached <= cfg_data[0];
		end
	end

	// stage 1 moves on when the result register is free or being drained
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			item_s1 <= '{op: op, port_select: port_select,
				write_data: write_data, card_reply: card_reply};
	end

	bsca_engine u_engine (
		.item    (item_s1),
		.cfg     (cfg_q),
		.st      (st_q),
		.res     (res),
		.st_next (st_next)
	);

	// adapter state commits with the access that leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{reply_latch: BYTE_ONES, shift_byte: BYTE_ZERO,
				bit_count: 3'd0, last_clock_level: 1'b0};
		end else if (advance) begin
			st_q <= st_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_s2 <= res;
	end

	assign out_valid      = valid_s2;
	assign read_data      = res_s2.read_data;
	assign exchange_valid = res_s2.exchange_valid;
	assign exchange_byte  = res_s2.exchange_byte;
	assign select_update  = res_s2.select_update;
	assign select_level   = res_s2.select_level;

	// adapter state only moves when an access retires from stage 1
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(advance) |-> $stable(st_q))
		else $error("adapter state changed without an access");

	// a byte is only reported with a card attached and on a write
	a_xchg_write: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.exchange_valid |-> cfg_q.card_attached && item_s1.op == OP_WRITE)
		else $error("exchange on read or without card");

	// unused result fields stay zero
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !exchange_valid |-> exchange_byte == BYTE_ZERO && !select_level
			|| select_update)
		else $error("inactive result field not zero");

	// a full stage 1 blocked by a stalled result must not take a word
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !out_ready |-> !in_ready)
		else $error("input accepted while pipeline full");

endmodule
